// File: src/per_client_broadcast_decimator_top_defines.svh
// Assertion macros for the per-client broadcast decimator.
`ifndef PER_CLIENT_BROADCAST_DECIMATOR_TOP_DEFINES_SVH
`define PER_CLIENT_BROADCAST_DECIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcbd_pkg.sv
// Shared types and constants for the per-client broadcast decimator.
package pcbd_pkg;

    localparam int STEP_W = 64;
    localparam int KEY_W  = 32;
    localparam int RATE_W = 32;
    localparam int DIV_W  = RATE_W + 1;
    localparam int CNT_W  = $clog2(STEP_W);

    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_SET     = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_SCAN,
        S_APPLY,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic apply;
        logic step_inc;
        logic div_start;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_last;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: src/pcbd_div.sv
// Bit-serial restoring remainder unit: 64-bit dividend, 33-bit divisor.
module pcbd_div
    import pcbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic              o_rem_zero
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_dsor;

    logic [DIV_W:0]    w_sh;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_dvd[STEP_W-1]};
    assign w_diff = w_sh - {1'b0, r_dsor};
    assign w_ge   = (w_sh >= {1'b0, r_dsor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
            r_dvd <= {r_dvd[STEP_W-2:0], 1'b0};
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

// File: src/pcbd_ctrl.sv
// Command sequencer for the decimator: accept, advance or scan, apply or divide, deliver.
module pcbd_ctrl
    import pcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_stall
);

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_ADVANCE;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid) begin
                r_cmd <= t_cmd'(i_command);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_cmd'(i_command) == CMD_ADVANCE) ? S_ADV : S_SCAN;
                end
            end
            S_ADV: begin
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = (r_cmd == CMD_QUERY) ? S_DIV_GO : S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_RESULT;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_ADV: begin
                o_cmd.step_inc = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV_WAIT: begin
                o_cmd = '0;
            end
            S_RESULT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: src/pcbd_dp.sv
// Datapath: step counter, endpoint table, scan compare, remainder unit, result register.
module pcbd_dp
    import pcbd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_status        o_dp_status,
    input  logic              i_cfg_valid,
    input  logic [RATE_W-1:0] i_cfg_default_rate,
    input  logic [1:0]        i_command,
    input  logic [KEY_W-1:0]  i_endpoint,
    input  logic [RATE_W-1:0] i_rate_value,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_send,
    output logic [RATE_W-1:0] o_rate_used,
    output logic              o_status
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [RATE_W-1:0]        r_default_rate;
    logic [STEP_W-1:0]        r_step;

    t_cmd                     r_cmd;
    logic [KEY_W-1:0]         r_key;
    logic [RATE_W-1:0]        r_val;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]         r_mem_ep   [TABLE_ENTRIES];
    logic [RATE_W-1:0]        r_mem_rate [TABLE_ENTRIES];

    // scan pipeline: issue stage then compare stage
    logic [IW-1:0]            r_rd_idx;
    logic                     r_issue_done;
    logic                     r_q_live;
    logic                     r_q_vld;
    logic [IW-1:0]            r_q_idx;
    logic [KEY_W-1:0]         r_ep_q;
    logic [RATE_W-1:0]        r_rate_q;

    logic                     r_hit;
    logic [IW-1:0]            r_hit_idx;
    logic [RATE_W-1:0]        r_hit_rate;
    logic                     r_free_found;
    logic [IW-1:0]            r_free_idx;
    logic                     r_res_status;

    logic                     r_out_valid;
    logic                     r_out_send;
    logic [RATE_W-1:0]        r_out_rate;
    logic                     r_out_status;

    logic                     w_rd_en;
    logic                     w_wr_en;
    logic [IW-1:0]            w_wr_idx;
    logic [RATE_W-1:0]        w_rate;
    logic [DIV_W-1:0]         w_divisor;
    logic                     w_div_done;
    logic                     w_rem_zero;
    logic                     w_out_free;

    assign w_rd_en   = i_cmd.scan && !r_issue_done;
    assign w_wr_en   = i_cmd.apply && (r_cmd == CMD_SET) && (r_hit || r_free_found);
    assign w_wr_idx  = r_hit ? r_hit_idx : r_free_idx;
    assign w_rate    = r_hit ? r_hit_rate : r_default_rate;
    assign w_divisor = {1'b0, w_rate} + DIV_W'(1);
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_dp_status.scan_last = r_q_live && (r_q_idx == IW'(TABLE_ENTRIES - 1));
    assign o_dp_status.div_done  = w_div_done;
    assign o_dp_status.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_rate <= '0;
        end else if (i_cfg_valid) begin
            r_default_rate <= i_cfg_default_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.step_inc) begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= i_endpoint;
            r_val <= i_rate_value;
        end
    end

    // table storage, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_ep[w_wr_idx]   <= r_key;
            r_mem_rate[w_wr_idx] <= r_val;
        end
        if (w_rd_en) begin
            r_ep_q   <= r_mem_ep[r_rd_idx];
            r_rate_q <= r_mem_rate[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.apply) begin
            if (w_wr_en) begin
                r_valid[w_wr_idx] <= 1'b1;
            end else if (r_cmd == CMD_REMOVE && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx     <= '0;
            r_issue_done <= 1'b0;
            r_q_live     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_res_status <= 1'b0;
        end else begin
            r_q_live <= w_rd_en;
            if (i_cmd.capture) begin
                r_rd_idx     <= '0;
                r_issue_done <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_res_status <= 1'b0;
            end else begin
                if (w_rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                    if (r_rd_idx == IW'(TABLE_ENTRIES - 1)) begin
                        r_issue_done <= 1'b1;
                    end
                end
                if (r_q_live) begin
                    if (r_q_vld && (r_ep_q == r_key) && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_q_vld && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end
                if (i_cmd.apply && (r_cmd == CMD_SET) && !r_hit && !r_free_found) begin
                    r_res_status <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_q_vld <= r_valid[r_rd_idx];
            r_q_idx <= r_rd_idx;
        end
        if (r_q_live) begin
            if (r_q_vld && (r_ep_q == r_key) && !r_hit) begin
                r_hit_idx  <= r_q_idx;
                r_hit_rate <= r_rate_q;
            end
            if (!r_q_vld && !r_free_found) begin
                r_free_idx <= r_q_idx;
            end
        end
    end

    pcbd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_step),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    // result register parts the core from the output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_send   <= (r_cmd == CMD_QUERY) && w_rem_zero;
            r_out_rate   <= (r_cmd == CMD_QUERY) ? w_rate : '0;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_send      = r_out_send;
    assign o_rate_used = r_out_rate;
    assign o_status    = r_out_status;

endmodule

// File: src/per_client_broadcast_decimator_top.sv
// Top level: per-client broadcast decimator (controller plus datapath).
// Advance bypasses the table; set/remove scan the table and apply; query scans
// the table and then divides (one table entry per cycle in the scan, then one
// dividend bit per cycle in the remainder unit).
// One item in flight; the next beat can be taken in the cycle after the result loads.
// Synchronous active-low reset clears the counter, the valid bits and default_rate.
`include "per_client_broadcast_decimator_top_defines.svh"

module per_client_broadcast_decimator_top
    import pcbd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel (default_rate)
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RATE_W-1:0] i_cfg_default_rate,
    // input beat
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [KEY_W-1:0]  i_endpoint,
    input  logic [RATE_W-1:0] i_rate_value,
    // result beat
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_send,
    output logic [RATE_W-1:0] o_rate_used,
    output logic              o_status
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // The user must write only while idle; the block itself does not enforce it. The port is always open.
    assign o_cfg_ready = 1'b1;

    // Sequencer: holds the input stalled from accept until the result loads.
    pcbd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_stall   (o_stall)
    );

    // Table scan, step counter, remainder unit and the output register.
    pcbd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_dp_status        (w_status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_default_rate (i_cfg_default_rate),
        .i_command          (i_command),
        .i_endpoint         (i_endpoint),
        .i_rate_value       (i_rate_value),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_send             (o_send),
        .o_rate_used        (o_rate_used),
        .o_status           (o_status)
    );

    // An accepted beat closes the input until its result is loaded into the result register.
    `PCBD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input open right after accept")

    // A refused set never carries a query answer.
    `PCBD_ASSERT_NOW(a_status_excl, i_clk, i_rst_n, o_valid && o_status, !o_send && (o_rate_used == '0), "status beat carries query fields")

    // The result register is only loaded when its previous beat is gone.
    `PCBD_ASSERT_NOW(a_load_free, i_clk, i_rst_n, w_cmd.out_load, !o_valid || !i_stall, "result overwritten while stalled")

    // Scan completion and the divider finish never coincide.
    `PCBD_ASSERT_NOW(a_scan_div_excl, i_clk, i_rst_n, w_status.div_done, !w_cmd.scan, "divider finished during a scan")

endmodule
